// ----- design/gtvn_pkg.sv -----
// ----------------------------------------------------------------------------
// gtvn_pkg
// Types and constants shared by the grain texture value noise block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtvn_pkg;

    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_PAPER    = 2'd1,
        KIND_GRAPHITE = 2'd2,
        KIND_WASH     = 2'd3
    } t_grain_kind;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_S   = 32'd2246822519;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    localparam logic [16:0] Q16_ONE    = 17'd65536;
    localparam logic [16:0] Q16_HALF   = 17'd32768;
    localparam logic [17:0] Q16_THREE  = 18'd196608;

endpackage

`default_nettype wire

// ----- design/gtvn_octave.sv -----
// ----------------------------------------------------------------------------
// gtvn_octave
// One octave of hashed lattice value noise, seven register stages deep.
// ----------------------------------------------------------------------------
`default_nettype none

module gtvn_octave #(
    parameter int TILE_SIZE  = 512,
    parameter int LC_PAPER   = 1,
    parameter int SALT_PAPER = 11,
    parameter int LC_GRAPH   = 1,
    parameter int SALT_GRAPH = 21,
    parameter int LC_WASH    = 3,
    parameter int SALT_WASH  = 31
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  gtvn_pkg::t_grain_kind i_kind,
    input  logic [8:0]            i_x,
    input  logic [8:0]            i_y,
    output logic [16:0]           o_value
);
    import gtvn_pkg::*;

    localparam int PER_PAPER = ((TILE_SIZE >> LC_PAPER) < 1) ? 1 : (TILE_SIZE >> LC_PAPER);
    localparam int PER_GRAPH = ((TILE_SIZE >> LC_GRAPH) < 1) ? 1 : (TILE_SIZE >> LC_GRAPH);
    localparam int PER_WASH  = ((TILE_SIZE >> LC_WASH) < 1) ? 1 : (TILE_SIZE >> LC_WASH);
    localparam int REC_PAPER = 65536 / PER_PAPER;
    localparam int REC_GRAPH = 65536 / PER_GRAPH;
    localparam int REC_WASH  = 65536 / PER_WASH;
    localparam logic [31:0] SK_PAPER = 32'(64'(SALT_PAPER) * 64'(HASH_MUL_S));
    localparam logic [31:0] SK_GRAPH = 32'(64'(SALT_GRAPH) * 64'(HASH_MUL_S));
    localparam logic [31:0] SK_WASH  = 32'(64'(SALT_WASH) * 64'(HASH_MUL_S));

    logic [2:0]  lc;
    logic [11:0] per;
    logic [16:0] rec;
    logic [31:0] salt_k;

    always_comb begin
        case (i_kind)
            KIND_GRAPHITE: begin
                lc = 3'(LC_GRAPH); per = 12'(PER_GRAPH);
                rec = 17'(REC_GRAPH); salt_k = SK_GRAPH;
            end
            KIND_WASH: begin
                lc = 3'(LC_WASH); per = 12'(PER_WASH);
                rec = 17'(REC_WASH); salt_k = SK_WASH;
            end
            default: begin
                lc = 3'(LC_PAPER); per = 12'(PER_PAPER);
                rec = 17'(REC_PAPER); salt_k = SK_PAPER;
            end
        endcase
    end

    function automatic logic [8:0] f_wrap(input logic [7:0] q, input logic [24:0] prod,
                                          input logic [11:0] p);
        logic [20:0] rem;
        rem = 21'(q) - 21'(prod[24:16]) * 21'(p);
        if (rem >= 21'(p)) begin
            rem = rem - 21'(p);
        end
        return rem[8:0];
    endfunction

    function automatic logic [8:0] f_next(input logic [8:0] a, input logic [11:0] p);
        logic [11:0] nx;
        nx = 12'(a) + 12'd1;
        return (nx == p) ? 9'd0 : nx[8:0];
    endfunction

    function automatic logic [16:0] f_mix(input logic [16:0] a, input logic [16:0] b,
                                          input logic [16:0] w);
        logic [35:0] acc;
        acc = 36'(a) * 36'(Q16_ONE - w) + 36'(b) * 36'(w) + 36'(Q16_HALF);
        return 17'(acc >> 16);
    endfunction

    logic [7:0]  qx, qy;
    logic [8:0]  fx, fy;
    logic [8:0]  cmask;

    assign cmask = 9'((10'd1 << lc) - 10'd1);
    assign qx    = 8'(i_x >> lc);
    assign qy    = 8'(i_y >> lc);
    assign fx    = i_x & cmask;
    assign fy    = i_y & cmask;

    logic [7:0]  r_qx, r_qy;
    logic [24:0] r_px, r_py;
    logic [16:0] r_tx1, r_ty1;
    logic [8:0]  r_xa, r_xb, r_ya, r_yb;
    logic [31:0] r_ttx, r_tty;
    logic [16:0] r_tx2, r_ty2;
    logic [31:0] r_h0 [4];
    logic [49:0] r_psx, r_psy;
    logic [31:0] r_m [4];
    logic [16:0] r_sx4, r_sy4;
    logic [16:0] r_v [4];
    logic [16:0] r_sx5, r_sy5;
    logic [16:0] r_top, r_bot, r_sy6;
    logic [16:0] r_val;

    logic [8:0]  n_xa, n_ya;
    logic [8:0]  cx [4];
    logic [8:0]  cy [4];
    logic [31:0] mixed [4];
    logic [31:0] folded [4];

    assign n_xa = f_wrap(r_qx, r_px, per);
    assign n_ya = f_wrap(r_qy, r_py, per);
    assign cx[0] = r_xa; assign cy[0] = r_ya;
    assign cx[1] = r_xb; assign cy[1] = r_ya;
    assign cx[2] = r_xa; assign cy[2] = r_yb;
    assign cx[3] = r_xb; assign cy[3] = r_yb;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            mixed[k]  = r_h0[k] ^ (r_h0[k] >> 13);
            folded[k] = r_m[k] ^ (r_m[k] >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qx  <= qx;
            r_qy  <= qy;
            r_px  <= 25'(qx) * 25'(rec);
            r_py  <= 25'(qy) * 25'(rec);
            r_tx1 <= 17'((25'(fx) << 16) >> lc);
            r_ty1 <= 17'((25'(fy) << 16) >> lc);

            r_xa  <= n_xa;
            r_ya  <= n_ya;
            r_xb  <= f_next(n_xa, per);
            r_yb  <= f_next(n_ya, per);
            r_ttx <= 32'(34'(r_tx1) * 34'(r_tx1));
            r_tty <= 32'(34'(r_ty1) * 34'(r_ty1));
            r_tx2 <= r_tx1;
            r_ty2 <= r_ty1;

            for (int k = 0; k < 4; k++) begin
                r_h0[k] <= 32'(32'(cx[k]) * HASH_MUL_X) + 32'(32'(cy[k]) * HASH_MUL_Y)
                           + salt_k;
                r_m[k]  <= 32'(mixed[k] * HASH_MUL_MIX);
                r_v[k]  <= 17'(folded[k][15:0]) + 17'(folded[k][15]);
            end
            r_psx <= 50'(r_ttx) * 50'(Q16_THREE - {r_tx2, 1'b0});
            r_psy <= 50'(r_tty) * 50'(Q16_THREE - {r_ty2, 1'b0});

            r_sx4 <= 17'((r_psx + 50'h80000000) >> 32);
            r_sy4 <= 17'((r_psy + 50'h80000000) >> 32);
            r_sx5 <= r_sx4;
            r_sy5 <= r_sy4;

            r_top <= f_mix(r_v[0], r_v[1], r_sx5);
            r_bot <= f_mix(r_v[2], r_v[3], r_sx5);
            r_sy6 <= r_sy5;

            r_val <= f_mix(r_top, r_bot, r_sy6);
        end
    end

    assign o_value = r_val;

endmodule

`default_nettype wire

// ----- design/grain_texture_value_noise.sv -----
// ----------------------------------------------------------------------------
// grain_texture_value_noise
// Tileable grain byte per texture pixel from hashed lattice value noise.
// Throughput is one request per cycle; the whole pipeline holds while the
// output is stalled. Reset clears the valid bits and sets grain kind to none.
// ----------------------------------------------------------------------------
`default_nettype none

module grain_texture_value_noise #(
    parameter int TILE_SIZE = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_grain_kind_we,
    input  logic [1:0] i_grain_kind,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [8:0] i_pixel_x,
    input  logic [8:0] i_pixel_y,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_grain_level
);
    import gtvn_pkg::*;

    localparam int LAT = 16;

    t_grain_kind      r_kind;
    logic [LAT-1:0]   r_vld;
    logic             en;
    logic [16:0]      oct [3];

    assign en      = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_NONE;
            r_vld  <= '0;
        end else begin
            if (i_grain_kind_we) begin
                r_kind <= t_grain_kind'(i_grain_kind);
            end
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_valid};
            end
        end
    end

    gtvn_octave #(
        .TILE_SIZE(TILE_SIZE), .LC_PAPER(1), .SALT_PAPER(11),
        .LC_GRAPH(1), .SALT_GRAPH(21), .LC_WASH(3), .SALT_WASH(31)
    ) u_oct0 (
        .i_clk(i_clk), .i_en(en), .i_kind(r_kind),
        .i_x(i_pixel_x), .i_y(i_pixel_y), .o_value(oct[0])
    );

    gtvn_octave #(
        .TILE_SIZE(TILE_SIZE), .LC_PAPER(2), .SALT_PAPER(12),
        .LC_GRAPH(3), .SALT_GRAPH(22), .LC_WASH(5), .SALT_WASH(32)
    ) u_oct1 (
        .i_clk(i_clk), .i_en(en), .i_kind(r_kind),
        .i_x(i_pixel_x), .i_y(i_pixel_y), .o_value(oct[1])
    );

    gtvn_octave #(
        .TILE_SIZE(TILE_SIZE), .LC_PAPER(4), .SALT_PAPER(13),
        .LC_GRAPH(4), .SALT_GRAPH(13), .LC_WASH(4), .SALT_WASH(13)
    ) u_oct2 (
        .i_clk(i_clk), .i_en(en), .i_kind(r_kind),
        .i_x(i_pixel_x), .i_y(i_pixel_y), .o_value(oct[2])
    );

    logic [15:0] w0, w1, w2;
    logic [16:0] lo, hi, dv;
    logic [17:0] rcp;

    always_comb begin
        case (r_kind)
            KIND_PAPER: begin
                w0 = 16'd30147; w1 = 16'd22282; w2 = 16'd13107;
                lo = 17'd22282; hi = 17'd43254; dv = 17'd20972; rcp = 18'd204795;
            end
            KIND_WASH: begin
                w0 = 16'd36045; w1 = 16'd29491; w2 = 16'd0;
                lo = 17'd9830;  hi = 17'd55706; dv = 17'd45876; rcp = 18'd93621;
            end
            default: begin
                w0 = 16'd40632; w1 = 16'd24904; w2 = 16'd0;
                lo = 17'd9830;  hi = 17'd55706; dv = 17'd45876; rcp = 18'd93621;
            end
        endcase
    end

    logic [16:0] r_n [7];
    logic [31:0] r_num2;
    logic [49:0] r_prod2;
    logic        r_le2, r_ge2, r_le3, r_ge3;
    logic [16:0] r_q3, r_rem3;
    logic [16:0] r_t4, r_t5;
    logic [33:0] r_tt5;
    logic [50:0] r_p6;
    logic [16:0] r_s7;
    logic [16:0] r_value8;
    logic [7:0]  r_level;

    logic [15:0] d2;
    logic [31:0] num2;
    logic [17:0] value8;
    logic [24:0] level9;

    assign d2   = 16'(r_n[0] - lo);
    assign num2 = {d2, 16'b0} + 32'(dv >> 1);

    always_comb begin
        case (r_kind)
            KIND_PAPER:    value8 = 18'(r_s7);
            KIND_GRAPHITE: value8 = 18'd19661 + 18'((34'd45875 * 34'(r_s7) + 34'(Q16_HALF)) >> 16);
            KIND_WASH:     value8 = 18'd36045 + 18'((34'd29491 * 34'(r_n[6]) + 34'(Q16_HALF)) >> 16);
            default:       value8 = 18'(Q16_ONE);
        endcase
    end

    assign level9 = 25'(r_value8) * 25'd255 + 25'(Q16_HALF);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n[0] <= 17'((34'(w0) * 34'(oct[0]) + 34'(w1) * 34'(oct[1])
                           + 34'(w2) * 34'(oct[2]) + 34'(Q16_HALF)) >> 16);
            for (int k = 1; k < 7; k++) begin
                r_n[k] <= r_n[k-1];
            end

            r_le2   <= (r_n[0] <= lo);
            r_ge2   <= (r_n[0] >= hi);
            r_num2  <= num2;
            r_prod2 <= 50'(num2) * 50'(rcp);

            r_le3  <= r_le2;
            r_ge3  <= r_ge2;
            r_q3   <= 17'(r_prod2[49:32]);
            r_rem3 <= 17'(34'(r_num2) - 34'(r_prod2[49:32]) * 34'(dv));

            if (r_le3) begin
                r_t4 <= 17'd0;
            end else if (r_ge3) begin
                r_t4 <= Q16_ONE;
            end else begin
                r_t4 <= r_q3 + 17'(r_rem3 >= dv);
            end

            r_tt5 <= 34'(r_t4) * 34'(r_t4);
            r_t5  <= r_t4;

            r_p6 <= 51'(r_tt5) * 51'(Q16_THREE - {r_t5, 1'b0});

            r_s7 <= 17'((r_p6 + 51'h80000000) >> 32);

            r_value8 <= (value8 > 18'(Q16_ONE)) ? Q16_ONE : 17'(value8);

            r_level <= (level9[24:16] > 9'd255) ? 8'd255 : level9[23:16];
        end
    end

    assign o_grain_level = r_level;

    a_quot_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[9] && !r_le3 && !r_ge3 && (r_kind == KIND_PAPER || r_kind == KIND_GRAPHITE))
        |-> (18'(r_rem3) < 18'({dv, 1'b0})))
        else $error("threshold quotient needs more than one correction");

    a_smooth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[13] |-> (r_s7 <= Q16_ONE))
        else $error("smoothstep result above one");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_vld) && $stable(r_level)))
        else $error("pipeline moved while the output was stalled");

endmodule

`default_nettype wire
